/* design/toqe_pkg.sv */
`timescale 1ns / 1ps
package toqe_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TIME_W          = 32;
  localparam int SIZE_W          = 16;
  localparam int TAG_W           = 16;
  localparam int LIMIT_W         = 20;
  localparam int KIND_W          = 2;
  localparam logic [LIMIT_W-1:0] SIZE_LIMIT_RST = 20'd512;
  localparam logic [LIMIT_W-1:0] TOTAL_MAX      = 20'hFFFFF;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVICT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TRIM   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] time_key;
    logic [SIZE_W-1:0] size_units;
    logic [TAG_W-1:0]  file_tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_TRIM_CHK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_t;

endpackage

/* design/time_ordered_quota_evictor_core.sv */
`timescale 1ns / 1ps
// channel  | handshake              | word
// ---------+------------------------+-------------------------------------------
// in_      | start && !busy         | mode, time_key, size_units, file_tag
// out_     | out_valid, one cycle   | kind, rejected, entry_time/size/tag, total
// cfg_     | cfg_valid && cfg_ready | size_limit (20 bits), ready always high
//
// Insert: each stored entry with a later key is read and written back one
// place up through the single table memory, then the new entry is written;
// a full table rejects. Trim: per eviction a minimum search over all entries
// and a move down of the entries above it, then a done word; outputs registered.
// Reset clears count, total and state, sets limit to 512; table holds no reset.
// The receiver cannot stall; busy holds off start while a word is in work.
module time_ordered_quota_evictor_core #(
  parameter int TABLE_DEPTH = toqe_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [toqe_pkg::TIME_W-1:0]    in_time_key,
  input  logic [toqe_pkg::SIZE_W-1:0]    in_size_units,
  input  logic [toqe_pkg::TAG_W-1:0]     in_file_tag,
  output logic                           out_valid,
  output logic [toqe_pkg::KIND_W-1:0]    out_kind,
  output logic                           out_rejected,
  output logic [toqe_pkg::TIME_W-1:0]    out_entry_time,
  output logic [toqe_pkg::SIZE_W-1:0]    out_entry_size,
  output logic [toqe_pkg::TAG_W-1:0]     out_entry_tag,
  output logic [toqe_pkg::LIMIT_W-1:0]   out_total_size,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [toqe_pkg::LIMIT_W-1:0]   cfg_size_limit
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = $clog2(TABLE_DEPTH * 65535 + 1);
  localparam int TOT_W = (SUM_W > toqe_pkg::LIMIT_W) ? SUM_W : toqe_pkg::LIMIT_W;
  localparam int XW    = CNT_W + 1;

  toqe_pkg::entry_t mem [TABLE_DEPTH];
  toqe_pkg::entry_t rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  toqe_pkg::entry_t mem_wdata;

  toqe_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [toqe_pkg::LIMIT_W-1:0] limit_r;
  toqe_pkg::entry_t new_r, new_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [AW-1:0]    min_idx_r, min_idx_nxt;
  toqe_pkg::entry_t min_r, min_nxt;

  logic                         ov_nxt, orej_nxt, olast_nxt;
  logic [toqe_pkg::KIND_W-1:0]  okind_nxt;
  toqe_pkg::entry_t             oent_nxt;
  logic [TOT_W-1:0]             otot_src;
  logic [toqe_pkg::LIMIT_W-1:0] otot_nxt;

  logic accept, over_limit, shift_more;

  assign accept     = start && (state_r == toqe_pkg::ST_IDLE);
  assign busy       = (state_r != toqe_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign over_limit = (total_r > TOT_W'(limit_r)) && (count_r != '0);
  assign shift_more = (XW'(idx_r) + XW'(1)) < XW'(count_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      toqe_pkg::ST_IDLE: begin
        if (accept && in_mode == toqe_pkg::MODE_TRIM) begin
          state_nxt = toqe_pkg::ST_TRIM_CHK;
        end else if (accept && XW'(count_r) < XW'(TABLE_DEPTH)) begin
          state_nxt = toqe_pkg::ST_INS_RD;
        end
      end
      toqe_pkg::ST_INS_RD: begin
        if (idx_r == '0) begin
          state_nxt = toqe_pkg::ST_IDLE;
        end else begin
          state_nxt = toqe_pkg::ST_INS_CMP;
        end
      end
      toqe_pkg::ST_INS_CMP: begin
        if (rdata_r.time_key > new_r.time_key) begin
          state_nxt = toqe_pkg::ST_INS_RD;
        end else begin
          state_nxt = toqe_pkg::ST_IDLE;
        end
      end
      toqe_pkg::ST_TRIM_CHK: begin
        if (over_limit) begin
          state_nxt = toqe_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = toqe_pkg::ST_IDLE;
        end
      end
      toqe_pkg::ST_SCAN_RD:  state_nxt = toqe_pkg::ST_SCAN_CMP;
      toqe_pkg::ST_SCAN_CMP: begin
        if (XW'(scan_r) + XW'(1) >= XW'(count_r)) begin
          state_nxt = toqe_pkg::ST_SHIFT_RD;
        end else begin
          state_nxt = toqe_pkg::ST_SCAN_RD;
        end
      end
      toqe_pkg::ST_SHIFT_RD: begin
        if (shift_more) begin
          state_nxt = toqe_pkg::ST_SHIFT_WR;
        end else begin
          state_nxt = toqe_pkg::ST_TRIM_CHK;
        end
      end
      toqe_pkg::ST_SHIFT_WR: state_nxt = toqe_pkg::ST_SHIFT_RD;
      default:               state_nxt = toqe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    total_nxt   = total_r;
    new_nxt     = new_r;
    idx_nxt     = idx_r;
    scan_nxt    = scan_r;
    min_idx_nxt = min_idx_r;
    min_nxt     = min_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_raddr   = idx_r;
    mem_wdata   = new_r;
    ov_nxt      = 1'b0;
    okind_nxt   = toqe_pkg::KIND_ACK;
    orej_nxt    = 1'b0;
    olast_nxt   = 1'b1;
    oent_nxt    = '0;
    otot_src    = total_r;
    case (state_r)
      toqe_pkg::ST_IDLE: begin
        if (accept) begin
          new_nxt = '{in_time_key, in_size_units, in_file_tag};
          idx_nxt = AW'(count_r);
          if (in_mode == toqe_pkg::MODE_INSERT &&
              XW'(count_r) >= XW'(TABLE_DEPTH)) begin
            ov_nxt   = 1'b1;
            orej_nxt = 1'b1;
          end
        end
      end
      toqe_pkg::ST_INS_RD: begin
        mem_raddr = idx_r - AW'(1);
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          total_nxt = total_r + TOT_W'(new_r.size_units);
          ov_nxt    = 1'b1;
          otot_src  = total_nxt;
        end
      end
      toqe_pkg::ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_r.time_key > new_r.time_key) begin
          mem_wdata = rdata_r;
          idx_nxt   = idx_r - AW'(1);
        end else begin
          count_nxt = count_r + CNT_W'(1);
          total_nxt = total_r + TOT_W'(new_r.size_units);
          ov_nxt    = 1'b1;
          otot_src  = total_nxt;
        end
      end
      toqe_pkg::ST_TRIM_CHK: begin
        scan_nxt = '0;
        if (!over_limit) begin
          ov_nxt    = 1'b1;
          okind_nxt = toqe_pkg::KIND_DONE;
        end
      end
      toqe_pkg::ST_SCAN_RD: begin
        mem_raddr = scan_r[AW-1:0];
      end
      toqe_pkg::ST_SCAN_CMP: begin
        if (scan_r == '0 || rdata_r.size_units < min_r.size_units) begin
          min_nxt     = rdata_r;
          min_idx_nxt = scan_r[AW-1:0];
        end
        scan_nxt = scan_r + CNT_W'(1);
        idx_nxt  = min_idx_nxt;
      end
      toqe_pkg::ST_SHIFT_RD: begin
        mem_raddr = idx_r + AW'(1);
        if (!shift_more) begin
          count_nxt = count_r - CNT_W'(1);
          total_nxt = total_r - TOT_W'(min_r.size_units);
          ov_nxt    = 1'b1;
          okind_nxt = toqe_pkg::KIND_EVICT;
          olast_nxt = 1'b0;
          oent_nxt  = min_r;
          otot_src  = total_nxt;
        end
      end
      toqe_pkg::ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        idx_nxt   = idx_r + AW'(1);
      end
      default: begin
      end
    endcase
    if (otot_src > TOT_W'(toqe_pkg::TOTAL_MAX)) begin
      otot_nxt = toqe_pkg::TOTAL_MAX;
    end else begin
      otot_nxt = otot_src[toqe_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= toqe_pkg::ST_IDLE;
      count_r   <= '0;
      total_r   <= '0;
      limit_r   <= toqe_pkg::SIZE_LIMIT_RST;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      out_valid <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_size_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    new_r          <= new_nxt;
    idx_r          <= idx_nxt;
    scan_r         <= scan_nxt;
    min_idx_r      <= min_idx_nxt;
    min_r          <= min_nxt;
    out_kind       <= okind_nxt;
    out_rejected   <= orej_nxt;
    out_last       <= olast_nxt;
    out_entry_time <= oent_nxt.time_key;
    out_entry_size <= oent_nxt.size_units;
    out_entry_tag  <= oent_nxt.file_tag;
    out_total_size <= otot_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= XW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == toqe_pkg::KIND_EVICT |-> !out_last && !out_rejected)
    else $error("eviction word marked last or rejected");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == toqe_pkg::MODE_TRIM |=> busy)
    else $error("trim accepted without going busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy || $past(accept))
    else $error("last word while work still pending");

endmodule
